[hw/rtl/pr80_pkg.sv]
// shared types, constants and round functions of the present-80 cipher
`timescale 1ns / 1ps
`default_nettype none
package pr80_pkg;

  // block and key geometry
  localparam int unsigned BLOCK_W  = 64;
  localparam int unsigned KEY_W    = 80;
  localparam int unsigned KEY_LO_W = 16;
  localparam int unsigned ROUNDS   = 31;
  localparam int unsigned NKEYS    = ROUNDS + 1;
  localparam int unsigned RK_IDX_W = $clog2(NKEYS);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

  // commands from controller to datapath
  typedef struct packed {
    logic                kload;    // load the key schedule register from the key registers
    logic                kstep;    // write one round key and advance the schedule
    logic [RK_IDX_W-1:0] kidx;     // round key slot being written
    logic                s_load;   // take a new block into the state
    logic                rd_en;    // fetch a round key
    logic [RK_IDX_W-1:0] rd_idx;   // round number of the fetch
    logic                round;    // one full round on the state
    logic                final_s;  // final key add into the state
    logic                out_load; // load the result register
    logic                out_xor;  // result is state xor key, else the state itself
  } pr80_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic key_wr; // a key register is written this cycle
  } pr80_stat_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;  4'h1: y = 4'h5;  4'h2: y = 4'h6;  4'h3: y = 4'hB;
      4'h4: y = 4'h9;  4'h5: y = 4'h0;  4'h6: y = 4'hA;  4'h7: y = 4'hD;
      4'h8: y = 4'h3;  4'h9: y = 4'hE;  4'hA: y = 4'hF;  4'hB: y = 4'h8;
      4'hC: y = 4'h4;  4'hD: y = 4'h7;  4'hE: y = 4'h1;  4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h5;  4'h1: y = 4'hE;  4'h2: y = 4'hF;  4'h3: y = 4'h8;
      4'h4: y = 4'hC;  4'h5: y = 4'h1;  4'h6: y = 4'h2;  4'h7: y = 4'hD;
      4'h8: y = 4'hB;  4'h9: y = 4'h4;  4'hA: y = 4'h6;  4'hB: y = 4'h3;
      4'hC: y = 4'h0;  4'hD: y = 4'h7;  4'hE: y = 4'h9;  4'hF: y = 4'hA;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    o = '0;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      o[4*n +: 4] = sbox_fwd(s[4*n +: 4]);
    end
    return o;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    o = '0;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      o[4*n +: 4] = sbox_inv(s[4*n +: 4]);
    end
    return o;
  endfunction

  // bit i moves to 16*i mod 63 and bit 63 stays, i.e. the 2-bit and 4-bit index fields swap places
  function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    logic [5:0]         i;
    o = '0;
    for (int n = 0; n < BLOCK_W; n++) begin
      i = 6'(n);
      o[{i[1:0], i[5:2]}] = s[n];
    end
    return o;
  endfunction

  // bit i moves to 4*i mod 63, bit 63 stays
  function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    logic [5:0]         i;
    o = '0;
    for (int n = 0; n < BLOCK_W; n++) begin
      i = 6'(n);
      o[{i[3:0], i[5:4]}] = s[n];
    end
    return o;
  endfunction

  // key schedule step: rotate left by 61, s-box on top nibble, counter into bits 19..15
  function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                  input logic [4:0] r);
    logic [KEY_W-1:0] t;
    t = {k[18:0], k[KEY_W-1:19]};
    t[79:76] = sbox_fwd(t[79:76]);
    t[19:15] = t[19:15] ^ r;
    return t;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pr80_in_if.sv]
// input item channel: block and direction with valid/ready
`timescale 1ns / 1ps
`default_nettype none
interface pr80_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink (input valid, input action, input data_in, output ready);
endinterface
`default_nettype wire

[hw/rtl/pr80_out_if.sv]
// result item channel: processed block with valid/ready
`timescale 1ns / 1ps
`default_nettype none
interface pr80_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface
`default_nettype wire

[hw/rtl/present80_block_cipher.sv]
// top level of the present-80 block cipher
// items are taken one at a time: a new one is accepted only after the result of the last is loaded,
// and the single round unit does one round a cycle with its round key fetched ahead
//   from the key memory
// reset: synchronous, clears the key to zero and expands its round keys, during which no item
//   is taken; a key write repeats that expansion
`timescale 1ns / 1ps
`default_nettype none
module present80_block_cipher (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pr80_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pr80_pkg::CFG_DATA_W-1:0] cfg_data,
  pr80_in_if.sink                              req,
  pr80_out_if.source                           rsp
);
  import pr80_pkg::*;

  pr80_cmd_t  cmd;
  pr80_stat_t stat;

  // sequencing
  pr80_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // key schedule and rounds
  pr80_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (req.action),
    .data_in   (req.data_in),
    .data_out  (rsp.data_out),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

[hw/rtl/pr80_dpath.sv]
// datapath: key registers, key schedule, round key memory and round unit
`timescale 1ns / 1ps
`default_nettype none
module pr80_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [pr80_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pr80_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               action,
  input  wire logic [pr80_pkg::BLOCK_W-1:0]       data_in,
  output logic      [pr80_pkg::BLOCK_W-1:0]       data_out,
  input  wire pr80_pkg::pr80_cmd_t                cmd,
  output pr80_pkg::pr80_stat_t                    stat
);
  import pr80_pkg::*;

  logic [BLOCK_W-1:0]          key_high;
  logic [KEY_LO_W-1:0]         key_low;
  logic [KEY_W-1:0]            kreg;
  logic [BLOCK_W-1:0]          rk_mem [NKEYS];
  logic [BLOCK_W-1:0]          key_q;
  logic [RK_IDX_W-1:0]         raddr;
  logic                        act;
  logic                        act_sel;
  logic [BLOCK_W-1:0]          s;
  logic [BLOCK_W-1:0]          s_mix;
  logic [BLOCK_W-1:0]          s_round;

  // key register writes, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data[KEY_LO_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.key_wr = cfg_we && ((cfg_index == REG_KEY_HIGH) || (cfg_index == REG_KEY_LOW));

  // key schedule register
  always_ff @(posedge clk) begin
    if (cmd.kload) begin
      kreg <= {key_high, key_low};
    end else if (cmd.kstep) begin
      kreg <= key_update(kreg, cmd.kidx + RK_IDX_W'(1));
    end
  end

  // round key memory, written during expansion, registered read
  always_ff @(posedge clk) begin
    if (cmd.kstep) begin
      rk_mem[cmd.kidx] <= kreg[KEY_W-1:KEY_W-BLOCK_W];
    end
  end

  // decryption walks the keys from the top down
  assign act_sel = cmd.s_load ? action : act;
  assign raddr   = act_sel ? ~cmd.rd_idx : cmd.rd_idx;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      key_q <= rk_mem[raddr];
    end
  end

  // round unit: key add, then sbox/perm, or inverse perm/sbox to decrypt
  assign s_mix   = s ^ key_q;
  assign s_round = act ? sub_inv(perm_inv(s_mix)) : perm_fwd(sub_fwd(s_mix));

  always_ff @(posedge clk) begin
    if (cmd.s_load) begin
      s   <= data_in;
      act <= action;
    end else if (cmd.round) begin
      s <= s_round;
    end else if (cmd.final_s) begin
      s <= s_mix;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      data_out <= cmd.out_xor ? s_mix : s;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pr80_ctrl.sv]
// controller: key expansion sequencing, round counting and handshakes
`timescale 1ns / 1ps
`default_nettype none
module pr80_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire pr80_pkg::pr80_stat_t stat,
  output pr80_pkg::pr80_cmd_t       cmd
);
  import pr80_pkg::*;

  localparam logic [2:0] ST_KLOAD  = 3'd0;
  localparam logic [2:0] ST_EXPAND = 3'd1;
  localparam logic [2:0] ST_IDLE   = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [RK_IDX_W-1:0] LAST = RK_IDX_W'(NKEYS - 1);

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [RK_IDX_W-1:0] cnt;
  logic [RK_IDX_W-1:0] cnt_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    case (state)
      ST_KLOAD: begin
        cmd.kload  = 1'b1;
        cnt_next   = '0;
        state_next = ST_EXPAND;
      end
      ST_EXPAND: begin
        cmd.kstep = 1'b1;
        cmd.kidx  = cnt;
        cnt_next  = cnt + RK_IDX_W'(1);
        if (cnt == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !stat.key_wr;
        if (in_valid && !stat.key_wr) begin
          cmd.s_load = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = '0;
          cnt_next   = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = cnt + RK_IDX_W'(1);
        if (cnt != LAST) begin
          cmd.round = 1'b1;
          cnt_next  = cnt + RK_IDX_W'(1);
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_xor  = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.final_s = 1'b1;
          state_next  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_KLOAD;
      end
    endcase
    // a key write restarts the expansion
    if (stat.key_wr) begin
      state_next = ST_KLOAD;
    end
  end

  // state, counter and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_KLOAD;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // an accepted item starts its first round next cycle
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !stat.key_wr) |=> (state == ST_RUN) && (cnt == '0))
    else $error("accepted item did not start rounds");

  // the result register is loaded only at the end of the rounds
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> ((state == ST_RUN) && (cnt == LAST)) || (state == ST_DONE))
    else $error("result loaded mid-computation");

  // no item taken while round keys are being written
  a_no_accept_expand: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EXPAND) || (state == ST_KLOAD)) |-> !in_ready)
    else $error("item accepted during key expansion");

  // a key write always leads to a fresh expansion
  a_key_restart: assert property (@(posedge clk) disable iff (rst)
    stat.key_wr |=> (state == ST_KLOAD))
    else $error("key write did not restart expansion");

  // a finished result is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("waiting result overwritten");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench of the present-80 block cipher with its own bit-level cipher model
`timescale 1ns / 1ps
module tb_top;
  import pr80_pkg::*;

  typedef logic [BLOCK_W-1:0] block_t;

  // direction codes of an input item
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  // register indexes that name no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // s-box tables, nibble n of the table is the image of n
  localparam logic [63:0] FWD_TAB = 64'h2174_8FE3_DA09_B65C;
  localparam logic [63:0] INV_TAB = 64'hA970_364B_D21C_8FE5;

  localparam int unsigned KEY_SETTLE    = 40;
  localparam int unsigned DRAIN_SLACK   = 40;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_BLOCKS = 1200;
  localparam int unsigned PHASES        = 8;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pr80_in_if  req_ch ();
  pr80_out_if rsp_ch ();

  // model copy of the key registers and the round key store
  block_t              key_high_q;
  logic [KEY_LO_W-1:0] key_low_q;
  block_t              round_keys [NKEYS];

  // blocks still owed by the cipher, oldest first
  block_t      pending_blocks [$];
  block_t      want_block;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          steady;
  int unsigned gap_odds;

  present80_block_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #5 clk = ~clk;

  // s-box applied to all sixteen nibbles
  function automatic block_t nibble_layer(block_t s, logic [63:0] tab);
    block_t o;
    int     idx;
    o = '0;
    for (int n = 0; n < 16; n++) begin
      idx = s[4*n +: 4];
      o[4*n +: 4] = tab[4*idx +: 4];
    end
    return o;
  endfunction

  // bit i goes to i*mult mod 63, bit 63 stays; mult 16 forward, mult 4 inverse
  function automatic block_t bit_spread(block_t s, int unsigned mult);
    block_t      o;
    int unsigned dst;
    o = '0;
    for (int unsigned i = 0; i < 64; i++) begin
      dst = (i == 63) ? 63 : (i * mult) % 63;
      o[dst] = s[i];
    end
    return o;
  endfunction

  // key schedule: store top 64 bits, rotate left 61, s-box top nibble, counter into 19..15
  function automatic void expand_round_keys();
    logic [KEY_W-1:0] k;
    int               idx;
    k = {key_high_q, key_low_q};
    for (int r = 1; r <= NKEYS; r++) begin
      round_keys[r-1] = k[79:16];
      k = {k[18:0], k[79:19]};
      idx = k[79:76];
      k[79:76] = FWD_TAB[4*idx +: 4];
      k[19:15] = k[19:15] ^ r[4:0];
    end
  endfunction

  // expected result of one block under the current round keys
  function automatic block_t cipher_block(logic act, block_t data);
    block_t s;
    s = data;
    if (act == ACT_ENCRYPT) begin
      for (int r = 0; r < ROUNDS; r++) begin
        s = s ^ round_keys[r];
        s = nibble_layer(s, FWD_TAB);
        s = bit_spread(s, 16);
      end
      s = s ^ round_keys[ROUNDS];
    end else begin
      s = s ^ round_keys[ROUNDS];
      for (int r = ROUNDS - 1; r >= 0; r--) begin
        s = bit_spread(s, 4);
        s = nibble_layer(s, INV_TAB);
        s = s ^ round_keys[r];
      end
    end
    return s;
  endfunction

  function automatic block_t rand_block();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // one register write, then time for the round key expansion to finish
  task automatic write_key_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_KEY_HIGH) begin
      key_high_q = value;
      expand_round_keys();
    end else if (idx == REG_KEY_LOW) begin
      key_low_q = value[KEY_LO_W-1:0];
      expand_round_keys();
    end
    repeat (KEY_SETTLE) @(negedge clk);
  endtask

  // offer one item, starting and ending at a falling edge
  task automatic send_block(logic act, block_t data);
    if (!steady && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.action  = act;
    req_ch.data_in = data;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_blocks.push_back(cipher_block(act, data));
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pending_blocks.size() != 0) @(negedge clk);
  endtask

  // all-zero key straight from reset, items held off during the expansion
  task automatic test_zero_key();
    gap_odds = 0;
    send_block(ACT_ENCRYPT, '0);
    send_block(ACT_ENCRYPT, '1);
    send_block(ACT_DECRYPT, '0);
    send_block(ACT_DECRYPT, '1);
    wait_results_drained();
  endtask

  // all-ones key, then a wide value into the low key register
  task automatic test_key_extremes();
    write_key_reg(REG_KEY_HIGH, '1);
    write_key_reg(REG_KEY_LOW, '1);
    send_block(ACT_ENCRYPT, '0);
    send_block(ACT_ENCRYPT, '1);
    send_block(ACT_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_block(ACT_DECRYPT, 64'h5555_5555_5555_5555);
    wait_results_drained();
    write_key_reg(REG_KEY_HIGH, '0);
    write_key_reg(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_0001);
    send_block(ACT_ENCRYPT, 64'h8000_0000_0000_0001);
    send_block(ACT_DECRYPT, 64'h0123_4567_89AB_CDEF);
    wait_results_drained();
  endtask

  // one key register changed on its own re-expands the whole store
  task automatic test_partial_key_update();
    gap_odds = 3;
    write_key_reg(REG_KEY_HIGH, rand_block());
    send_block(ACT_ENCRYPT, rand_block());
    send_block(ACT_DECRYPT, rand_block());
    wait_results_drained();
    write_key_reg(REG_KEY_LOW, rand_block());
    send_block(ACT_ENCRYPT, rand_block());
    send_block(ACT_DECRYPT, rand_block());
    wait_results_drained();
  endtask

  // writes to unused indexes leave the key alone; round trip through both directions
  task automatic test_spare_index();
    block_t plain;
    plain = rand_block();
    write_key_reg(REG_SPARE_A, rand_block());
    write_key_reg(REG_SPARE_B, rand_block());
    send_block(ACT_ENCRYPT, plain);
    send_block(ACT_DECRYPT, cipher_block(ACT_ENCRYPT, plain));
    wait_results_drained();
  endtask

  // phases of random blocks, each under a fresh key and idling pattern
  task automatic test_random_traffic();
    int unsigned per_phase;
    int unsigned sent;
    block_t      plain;
    per_phase = RANDOM_BLOCKS / PHASES;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      wait_results_drained();
      case (phase % 4)
        0: begin
          write_key_reg(REG_KEY_HIGH, rand_block());
          write_key_reg(REG_KEY_LOW, rand_block());
        end
        1: write_key_reg(REG_KEY_HIGH, rand_block());
        2: write_key_reg(REG_KEY_LOW, rand_block());
        default: begin
          write_key_reg(REG_KEY_HIGH, phase[2] ? '1 : '0);
          write_key_reg(REG_KEY_LOW, phase[2] ? '0 : '1);
        end
      endcase
      case ($urandom_range(0, 3))
        0: gap_odds = 0;
        1: gap_odds = 2;
        2: gap_odds = 4;
        default: gap_odds = 10;
      endcase
      // last phase runs with no idling on either side
      if (phase == PHASES - 1) begin
        steady = 1'b1;
      end
      sent = 0;
      while (sent < per_phase) begin
        // sender holds back once until the cipher has caught up
        if (phase == 2 && sent == per_phase / 2) begin
          wait_results_drained();
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            send_block(ACT_ENCRYPT, rand_block());
            sent++;
          end
          4, 5, 6: begin
            send_block(ACT_DECRYPT, rand_block());
            sent++;
          end
          7, 8: begin
            plain = rand_block();
            send_block(ACT_ENCRYPT, plain);
            send_block(ACT_DECRYPT, cipher_block(ACT_ENCRYPT, plain));
            sent += 2;
          end
          default: begin
            case ($urandom_range(0, 2))
              0: plain = '0;
              1: plain = '1;
              default: plain = block_t'(1) << $urandom_range(0, 63);
            endcase
            send_block($urandom_range(0, 1) ? ACT_DECRYPT : ACT_ENCRYPT, plain);
            sent++;
          end
        endcase
      end
    end
  endtask

  task automatic finish_run();
    int unsigned waited;
    waited = 0;
    while (pending_blocks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_SLACK) @(negedge clk);
    if (pending_blocks.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_blocks.size()));
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  endtask

  // result checker on every accepted item
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("result %h with none expected", rsp_ch.data_out));
      end else begin
        want_block = pending_blocks.pop_front();
        if (rsp_ch.data_out !== want_block) begin
          report_mismatch($sformatf("data_out %h, expected %h", rsp_ch.data_out, want_block));
        end
      end
    end
  end

  // cycle counter
  always @(posedge clk) begin
    cycle_count++;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // result side stalls in bursts, with long stretches of steady acceptance
  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      rsp_ch.ready = 1'b1;
      repeat ($urandom_range(1, 80)) @(negedge clk);
      if (!steady && $urandom_range(0, 2) != 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
    end
  end

  // reset, then the tests in turn
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_KEY_HIGH;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_ENCRYPT;
    req_ch.data_in = '0;
    steady         = 1'b0;
    gap_odds       = 0;
    key_high_q     = '0;
    key_low_q      = '0;
    expand_round_keys();
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_zero_key();
    test_key_extremes();
    test_partial_key_update();
    test_spare_index();
    test_random_traffic();
    finish_run();
  end

endmodule
